// File: design/vertex_scale_rotate_translate_assert.svh
// Assertion helpers used by the vertex transform datapath.
`ifndef VERTEX_SCALE_ROTATE_TRANSLATE_ASSERT_SVH
`define VERTEX_SCALE_ROTATE_TRANSLATE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VSRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VSRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/vsrt_pkg.sv
`timescale 1ns / 1ps

package vsrt_pkg;

    // Fixed-point formats
    localparam int COORD_FRAC_BITS     = 8;
    localparam int TRIG_FRAC_BITS_DEF  = 15;
    localparam int TRIG_TABLE_FRAC     = 15;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS_X        = 3'd0,
        REG_POS_Y        = 3'd1,
        REG_SCALE_X      = 3'd2,
        REG_SCALE_Y      = 3'd3,
        REG_ROTATION_DEG = 3'd4
    } t_reg_idx;

    // Input beat
    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
    } t_in;

    // Output beat
    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
    } t_out;

    // Translation and scale, as held by the register block
    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
    } t_cfg;

    // Quarter-wave lookup: table index and sign
    typedef struct packed {
        logic       neg;
        logic [6:0] idx;
    } t_quad;

    // sin(k deg), k = 0..90, Q1.15
    localparam logic [15:0] SIN_Q15 [0:90] = '{
            0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
         5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
        11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
        16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
        21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
        25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
        28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
        30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
        32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
        32768
    };

    function automatic logic [15:0] tab_q15(input logic [6:0] idx);
        logic [15:0] e;
        begin
            if (idx > 7'd90) begin
                e = SIN_Q15[90];
            end else begin
                e = SIN_Q15[idx];
            end
            return e;
        end
    endfunction

    // Map an angle 0..359 onto the first quadrant
    function automatic t_quad quad_of(input logic [8:0] a);
        t_quad q;
        begin
            if (a <= 9'd90) begin
                q.neg = 1'b0;
                q.idx = a[6:0];
            end else if (a <= 9'd180) begin
                q.neg = 1'b0;
                q.idx = 7'(9'd180 - a);
            end else if (a <= 9'd270) begin
                q.neg = 1'b1;
                q.idx = 7'(a - 9'd180);
            end else begin
                q.neg = 1'b1;
                q.idx = 7'(9'd360 - a);
            end
            return q;
        end
    endfunction

endpackage

// File: design/vsrt_cfg.sv
`timescale 1ns / 1ps

module vsrt_cfg #(
    parameter int TRIG_FRAC_BITS = vsrt_pkg::TRIG_FRAC_BITS_DEF,
    localparam int TW = TRIG_FRAC_BITS + 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vsrt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [vsrt_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output vsrt_pkg::t_cfg                      o_cfg,
    output logic signed [TW-1:0]                o_sin,
    output logic signed [TW-1:0]                o_cos
);

    // Table entries are reduced from Q1.15 to the configured trig precision
    localparam int          RSH  = vsrt_pkg::TRIG_TABLE_FRAC - TRIG_FRAC_BITS;
    localparam logic [17:0] RHALF = (18'(1) << RSH) >> 1;

    function automatic logic signed [TW-1:0] trig_val(input vsrt_pkg::t_quad q);
        logic [17:0]          ent;
        logic signed [TW-1:0] mag;
        begin
            ent = ({2'b00, vsrt_pkg::tab_q15(q.idx)} + RHALF) >> RSH;
            mag = $signed({1'b0, ent[TW-2:0]});
            return q.neg ? -mag : mag;
        end
    endfunction

    logic signed [23:0]   r_pos_x, r_pos_y;
    logic signed [15:0]   r_scale_x, r_scale_y;
    logic signed [TW-1:0] r_sin, r_cos;

    logic [8:0]           deg_raw, deg_sin, deg_cos;
    logic [9:0]           deg_plus;
    logic signed [TW-1:0] n_sin, n_cos;

    // Angle wrap and sine/cosine lookup on the write data
    always_comb begin
        deg_raw  = i_cfg_wdata[8:0];
        deg_sin  = (deg_raw >= 9'd360) ? (deg_raw - 9'd360) : deg_raw;
        deg_plus = {1'b0, deg_sin} + 10'd90;
        deg_cos  = (deg_plus >= 10'd360) ? 9'(deg_plus - 10'd360) : deg_plus[8:0];
        n_sin    = trig_val(vsrt_pkg::quad_of(deg_sin));
        n_cos    = trig_val(vsrt_pkg::quad_of(deg_cos));
    end

    // Register writes; the angle is kept as its sine and cosine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_scale_x <= '0;
            r_scale_y <= '0;
            r_sin     <= '0;
            r_cos     <= TW'(1) << TRIG_FRAC_BITS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vsrt_pkg::REG_POS_X:        r_pos_x   <= i_cfg_wdata;
                vsrt_pkg::REG_POS_Y:        r_pos_y   <= i_cfg_wdata;
                vsrt_pkg::REG_SCALE_X:      r_scale_x <= i_cfg_wdata[15:0];
                vsrt_pkg::REG_SCALE_Y:      r_scale_y <= i_cfg_wdata[15:0];
                vsrt_pkg::REG_ROTATION_DEG: begin
                    r_sin <= n_sin;
                    r_cos <= n_cos;
                end
                default: ;
            endcase
        end
    end

    assign o_cfg.pos_x   = r_pos_x;
    assign o_cfg.pos_y   = r_pos_y;
    assign o_cfg.scale_x = r_scale_x;
    assign o_cfg.scale_y = r_scale_y;
    assign o_sin         = r_sin;
    assign o_cos         = r_cos;

endmodule

// File: design/vsrt_datapath.sv
`timescale 1ns / 1ps
`include "vertex_scale_rotate_translate_assert.svh"

module vsrt_datapath #(
    parameter int TRIG_FRAC_BITS = vsrt_pkg::TRIG_FRAC_BITS_DEF,
    localparam int TW = TRIG_FRAC_BITS + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  vsrt_pkg::t_in        i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output vsrt_pkg::t_out       o_out_data,
    input  vsrt_pkg::t_cfg       i_cfg,
    input  logic signed [TW-1:0] i_sin,
    input  logic signed [TW-1:0] i_cos
);

    // Widths through the pipe
    localparam int XW  = 32;                               // scaled coordinate
    localparam int PW  = XW + TW;                          // rotation product
    localparam int SW  = PW + 1;                           // product sum
    localparam int SH  = vsrt_pkg::COORD_FRAC_BITS + TRIG_FRAC_BITS;
    localparam int RW  = SW - SH;                          // rounded rotation
    localparam int AW  = ((RW > 24) ? RW : 24) + 1;        // after translation
    localparam int WW  = (AW > 32) ? AW : 33;              // saturation compare
    localparam logic signed [SW-1:0] RND  = SW'(1) <<< (SH - 1);
    localparam logic signed [WW-1:0] SMAX = WW'(32'sh7FFF_FFFF);
    localparam logic signed [WW-1:0] SMIN = WW'(32'sh8000_0000);

    logic en1, en2, en3, en4, en5;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    logic signed [15:0]   r_vx, r_vy;
    logic signed [XW-1:0] r_xs, r_ys;
    logic signed [PW-1:0] r_cx, r_sx, r_sy, r_cy;
    logic signed [RW-1:0] r_rx, r_ry;
    vsrt_pkg::t_out       r_out;

    logic signed [XW-1:0] xs, ys;
    logic signed [PW-1:0] cx, sx, sy, cy;
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [AW-1:0] add_x, add_y;
    logic signed [WW-1:0] wide_x, wide_y;
    logic signed [31:0]   sat_x, sat_y;

    // Per-stage advance: a stage moves when it is empty or its successor moves
    assign en5 = ~r_v5 | i_out_ready;
    assign en4 = ~r_v4 | en5;
    assign en3 = ~r_v3 | en4;
    assign en2 = ~r_v2 | en3;
    assign en1 = ~r_v1 | en2;
    assign o_in_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // Stage 2: per-axis scale
    assign xs = $signed(i_cfg.scale_x) * r_vx;
    assign ys = $signed(i_cfg.scale_y) * r_vy;

    // Stage 3: four rotation products
    assign cx = i_cos * r_xs;
    assign sx = i_sin * r_xs;
    assign sy = i_sin * r_ys;
    assign cy = i_cos * r_ys;

    // Stage 4: combine and round half up
    assign sum_x = SW'(r_cx) - SW'(r_sy) + RND;
    assign sum_y = SW'(r_sx) + SW'(r_cy) + RND;

    // Stage 5: translate and clamp to 32 bits
    always_comb begin
        add_x  = AW'(r_rx) + AW'($signed(i_cfg.pos_x));
        add_y  = AW'(r_ry) + AW'($signed(i_cfg.pos_y));
        wide_x = WW'(add_x);
        wide_y = WW'(add_y);
        if (wide_x > SMAX)      sat_x = SMAX[31:0];
        else if (wide_x < SMIN) sat_x = SMIN[31:0];
        else                    sat_x = wide_x[31:0];
        if (wide_y > SMAX)      sat_y = SMAX[31:0];
        else if (wide_y < SMIN) sat_y = SMIN[31:0];
        else                    sat_y = wide_y[31:0];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (en1 && i_in_valid) begin
            r_vx <= i_in_data.vertex_x;
            r_vy <= i_in_data.vertex_y;
        end
        if (en2 && r_v1) begin
            r_xs <= xs;
            r_ys <= ys;
        end
        if (en3 && r_v2) begin
            r_cx <= cx;
            r_sx <= sx;
            r_sy <= sy;
            r_cy <= cy;
        end
        if (en4 && r_v3) begin
            r_rx <= sum_x[SW-1:SH];
            r_ry <= sum_y[SW-1:SH];
        end
        if (en5 && r_v4) begin
            r_out.out_x <= sat_x;
            r_out.out_y <= sat_y;
        end
    end

    assign o_out_valid = r_v5;
    assign o_out_data  = r_out;

    // Checks on the pipeline control
    `VSRT_ASSERT_NOW(a_ready_only_when_full, i_clk, i_rst_n, !o_in_ready, r_v1,
        "input refused while first stage is empty")
    `VSRT_ASSERT_NEXT(a_accept_fills_stage1, i_clk, i_rst_n, i_in_valid && o_in_ready, r_v1,
        "accepted beat did not reach first stage")
    `VSRT_ASSERT_NEXT(a_stage2_moves_on, i_clk, i_rst_n, r_v2 && en3, r_v3,
        "beat lost between scale and rotate stages")
    `VSRT_ASSERT_NEXT(a_stall_holds_stage4, i_clk, i_rst_n, r_v4 && r_v5 && !i_out_ready,
        r_v4 && $stable(r_rx) && $stable(r_ry), "stalled beat in round stage was dropped")

endmodule

// File: design/vertex_scale_rotate_translate.sv
`timescale 1ns / 1ps

// Vertex scale / rotate / translate, one 2D vertex per beat.
// Input channel: i_in_valid / o_in_ready carry vertex_x, vertex_y (Q8.8).
// Output channel: o_out_valid / i_out_ready carry out_x, out_y (Q24.8),
// one result per vertex, in order, rounded half up and clamped to 32 bits.
// Config port: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
// (pos_x, pos_y, scale_x, scale_y, rotation_deg); write only while idle.
// The angle is turned into sine and cosine at write time.
// Pipeline: five register stages, an input register followed by scale,
// rotate products, round and translate/clamp, in that order.
// Throughput: one beat per clock while the receiver keeps i_out_ready
// high; a receiver stall holds the beats once the pipe is full.
// Reset clears the config registers to zero (cosine to one) and empties the pipe;
// every vertex then maps to (pos_x, pos_y).
// When the receiver stalls, each stage holds only if the one after it is
// full; bubbles still fill, so input keeps flowing until the pipe is full.
module vertex_scale_rotate_translate #(
    parameter int TRIG_FRAC_BITS = vsrt_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  vsrt_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output vsrt_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_we,
    input  logic [vsrt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vsrt_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int TW = TRIG_FRAC_BITS + 2;

    vsrt_pkg::t_cfg       cfg;
    logic signed [TW-1:0] trig_sin, trig_cos;

    // Configuration registers and trig lookup
    vsrt_cfg #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg),
        .o_sin       (trig_sin),
        .o_cos       (trig_cos)
    );

    // Transform pipeline
    vsrt_datapath #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg       (cfg),
        .i_sin       (trig_sin),
        .i_cos       (trig_cos)
    );

endmodule
